FILE: sv/first_fit_heap_allocator_assert.svh
// assertion macros for the heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// implication checked on every clock outside reset
`define FFHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// types, constants and status codes of the first fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;
  localparam int unsigned HeapBytes = 4096;
  localparam int unsigned AddrW = $clog2(HeapBytes);
  localparam int unsigned Hdr = 4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StZero     = 3'd1;
  localparam logic [2:0] StTooLarge = 3'd2;
  localparam logic [2:0] StNoSpace  = 3'd3;
  localparam logic [2:0] StOutside  = 3'd4;
  localparam logic [2:0] StNotAlloc = 3'd5;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] request_bytes;
    logic [11:0] data_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] block_offset;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpRdCur, OpStepAlloc, OpWrFmt, OpWrUsed, OpWrSplitN,
    OpWrSplitH, OpStepFree, OpRdTgt, OpRdN3, OpWrTgt, OpRdPrev, OpWrPrev
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic fit_free;
    logic fit_split;
    logic alloc_stop;
    logic free_found;
    logic free_prev;
    logic free_out;
    logic free_bad;
    logic tgt_free;
    logic n3_in;
    logic n3_free;
    logic prev_free;
  } sts_t;
endpackage

FILE: sv/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// header memories, walk pointer and compare logic
// ----------------------------------------------------------------------------
module ffha_datapath (
  input  logic                clk_i,
  input  ffha_pkg::cmd_t      cmd_i,
  input  ffha_pkg::req_t      req_i,
  output ffha_pkg::sts_t      sts_o,
  output logic [11:0]         offset_o
);
  import ffha_pkg::*;

  localparam int unsigned W = AddrW + 2;

  logic [AddrW-1:0] span_mem [HeapBytes];
  logic [AddrW-1:0] used_mem [HeapBytes];

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] sp_q, us_q;
  logic [AddrW-1:0] h_q, h_d, prev_q, prev_d, tgt_q, tgt_d;
  logic [AddrW-1:0] tsp_q, tsp_d;
  logic [W-1:0]     req_q, req_d;
  logic [AddrW-1:0] res_q, res_d;
  logic             we;
  logic [AddrW-1:0] wa, wsp, wus;
  logic             wsp_en, wus_en;
  logic [W-1:0]     nxt, room, nsp;
  // capture target span after the target read
  logic             tgt_cap_q;

  assign nxt  = W'(h_q) + W'(Hdr) + W'(sp_q);
  assign room = W'(sp_q) - W'(us_q);

  always_comb begin
    rd_addr = h_q;
    unique case (cmd_i.op)
      OpRdN3:   rd_addr = AddrW'(W'(tgt_q) + W'(Hdr) + W'(tsp_q));
      OpRdPrev: rd_addr = prev_q;
      OpRdTgt:  rd_addr = tgt_q;
      default:  rd_addr = h_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sp_q <= span_mem[rd_addr];
    us_q <= used_mem[rd_addr];
    if (we && wsp_en) span_mem[wa] <= wsp;
    if (we && wus_en) used_mem[wa] <= wus;
  end

  always_comb begin
    sts_o.fit_free   = (W'(sp_q) >= req_q) && us_q == '0;
    sts_o.fit_split  = (W'(sp_q) >= req_q) && us_q <= sp_q && room >= req_q + W'(Hdr);
    sts_o.alloc_stop = sp_q == '0 || (nxt + W'(Hdr) + req_q > W'(HeapBytes));
    sts_o.free_found = h_q == tgt_q;
    sts_o.free_out   = nxt >= W'(HeapBytes);
    sts_o.free_prev  = nxt == W'(tgt_q);
    sts_o.free_bad   = nxt > W'(tgt_q);
    sts_o.tgt_free   = us_q == '0;
    sts_o.n3_in      = W'(tgt_q) + W'(Hdr) + W'(tsp_q) < W'(HeapBytes);
    sts_o.n3_free    = us_q == '0;
    sts_o.prev_free  = us_q == '0;
  end

  always_comb begin
    h_d = h_q; prev_d = prev_q; tgt_d = tgt_q; tsp_d = tsp_q;
    req_d = req_q; res_d = res_q;
    we = 1'b0; wa = h_q; wsp = sp_q; wus = us_q; wsp_en = 1'b0; wus_en = 1'b0;
    nsp = '0;
    unique case (cmd_i.op)
      OpLoad: begin
        h_d = '0;
        prev_d = '0;
        req_d = W'(req_i.request_bytes);
        tgt_d = AddrW'(req_i.data_offset - 12'(Hdr));
        res_d = '0;
      end
      OpStepAlloc: h_d = AddrW'(nxt);
      OpStepFree: begin
        if (sts_o.free_prev) prev_d = h_q;
        h_d = AddrW'(nxt);
      end
      OpWrFmt: begin
        we = 1'b1; wa = '0; wsp = AddrW'(HeapBytes - Hdr); wus = '0;
        wsp_en = 1'b1; wus_en = 1'b1;
      end
      OpWrUsed: begin
        we = 1'b1; wa = h_q; wus = AddrW'(req_q); wus_en = 1'b1;
        res_d = AddrW'(W'(h_q) + W'(Hdr));
      end
      OpWrSplitN: begin
        we = 1'b1; wa = AddrW'(W'(h_q) + W'(Hdr) + W'(us_q));
        wsp = AddrW'(room - W'(Hdr)); wus = AddrW'(req_q);
        wsp_en = 1'b1; wus_en = 1'b1;
        res_d = AddrW'(W'(h_q) + W'(2 * Hdr) + W'(us_q));
        tsp_d = us_q;
      end
      OpWrSplitH: begin
        we = 1'b1; wa = h_q; wsp = tsp_q; wsp_en = 1'b1;
      end
      OpWrTgt: begin
        // merge with next if free (us_q/sp_q hold n3 header here)
        nsp = W'(tsp_q);
        if (sts_o.n3_in && us_q == '0) nsp = W'(tsp_q) + W'(Hdr) + W'(sp_q);
        we = 1'b1; wa = tgt_q; wsp = AddrW'(nsp); wus = '0;
        wsp_en = 1'b1; wus_en = 1'b1;
        tsp_d = AddrW'(nsp);
      end
      OpWrPrev: begin
        we = 1'b1; wa = prev_q;
        wsp = AddrW'(W'(sp_q) + W'(Hdr) + W'(tsp_q)); wsp_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; prev_q <= prev_d; tgt_q <= tgt_d;
    req_q <= req_d; res_q <= res_d;
    tgt_cap_q <= cmd_i.op == OpRdTgt;
    if (tgt_cap_q) tsp_q <= sp_q;
    else tsp_q <= tsp_d;
  end

  assign offset_o = 12'(res_q);
endmodule

FILE: sv/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer for allocate and free walks
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffha_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output ffha_pkg::cmd_t  cmd_o,
  input  ffha_pkg::sts_t  sts_i
);
  import ffha_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SFmt = 4'd1, SARd = 4'd2, SAChk = 4'd3,
    SSplitH = 4'd4, SFRd = 4'd5, SFChk = 4'd6, STgtRd = 4'd7, STgtChk = 4'd8,
    SN3Rd = 4'd9, SN3Wait = 4'd10, SPrevRd = 4'd11, SPrevChk = 4'd12, SDone = 4'd13,
    STgtCap = 4'd14;

  logic [3:0] st_q, st_d;
  logic       fmt_q, fmt_d, hasp_q, hasp_d;
  logic [2:0] stat_q, stat_d;

  assign in_ready_o  = st_q == SIdle;
  assign out_valid_o = st_q == SDone;
  assign status_o    = stat_q;

  always_comb begin
    st_d = st_q; fmt_d = fmt_q; hasp_d = hasp_q; stat_d = stat_q;
    cmd_o.op = OpNone;
    unique case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.op = OpLoad; stat_d = StOk; hasp_d = 1'b0;
        if (in_data_i.mode == ModeAlloc) begin
          if (in_data_i.request_bytes == '0) begin stat_d = StZero; st_d = fmt_q ? SDone : SFmt; end
          else if (32'(in_data_i.request_bytes) > HeapBytes - Hdr) begin
            stat_d = StTooLarge; st_d = fmt_q ? SDone : SFmt;
          end else st_d = fmt_q ? SARd : SFmt;
        end else begin
          if (32'(in_data_i.data_offset) < Hdr) begin stat_d = StOutside; st_d = SDone; end
          else if (!fmt_q) begin stat_d = StNotAlloc; st_d = SDone; end
          else if (32'(in_data_i.data_offset) >= HeapBytes) begin
            stat_d = StOutside; st_d = SDone;
          end else st_d = SFRd;
        end
      end
      SFmt: begin
        cmd_o.op = OpWrFmt; fmt_d = 1'b1;
        st_d = (stat_q == StOk) ? SARd : SDone;
      end
      SARd: begin cmd_o.op = OpRdCur; st_d = SAChk; end
      SAChk: begin
        if (sts_i.fit_free) begin cmd_o.op = OpWrUsed; st_d = SDone; end
        else if (sts_i.fit_split) begin cmd_o.op = OpWrSplitN; st_d = SSplitH; end
        else if (sts_i.alloc_stop) begin stat_d = StNoSpace; st_d = SDone; end
        else begin cmd_o.op = OpStepAlloc; st_d = SARd; end
      end
      SSplitH: begin cmd_o.op = OpWrSplitH; st_d = SDone; end
      SFRd: begin
        cmd_o.op = OpRdCur; st_d = SFChk;
      end
      SFChk: begin
        if (sts_i.free_found) st_d = STgtRd;
        else if (sts_i.free_out) begin stat_d = StOutside; st_d = SDone; end
        else if (sts_i.free_prev) begin
          cmd_o.op = OpStepFree; hasp_d = 1'b1; st_d = STgtRd;
        end else if (sts_i.free_bad) begin stat_d = StNotAlloc; st_d = SDone; end
        else begin cmd_o.op = OpStepFree; st_d = SFRd; end
      end
      STgtRd: begin cmd_o.op = OpRdTgt; st_d = STgtCap; end
      STgtCap: st_d = STgtChk;
      STgtChk: begin
        if (sts_i.tgt_free) begin stat_d = StNotAlloc; st_d = SDone; end
        else begin cmd_o.op = OpRdN3; st_d = SN3Wait; end
      end
      SN3Wait: begin cmd_o.op = OpWrTgt; st_d = hasp_q ? SPrevRd : SDone; end
      SPrevRd: begin cmd_o.op = OpRdPrev; st_d = SPrevChk; end
      SPrevChk: begin
        if (sts_i.prev_free) cmd_o.op = OpWrPrev;
        st_d = SDone;
      end
      SDone: if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; fmt_q <= 1'b0; hasp_q <= 1'b0; stat_q <= StOk;
    end else begin
      st_q <= st_d; fmt_q <= fmt_d; hasp_q <= hasp_d; stat_q <= stat_d;
    end
  end
endmodule

FILE: sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first fit heap allocator with splitting and coalescing of free blocks
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i, in_ready_o, in_data_i
// out     | output    | out_valid_o, out_ready_i, out_data_o
//
// an allocate or a free walks the block headers one by one through the single
// header memory read port; one transaction at a time; the heap is formatted
// on the first allocate; a stalled result holds the block; reset clears
// control state only
module first_fit_heap_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffha_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ffha_pkg::rsp_t  out_data_o
);
  import ffha_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [11:0] offset;
  logic [2:0]  status;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .status_o(status), .cmd_o(cmd), .sts_i(sts)
  );

  ffha_datapath u_dp (
    .clk_i, .cmd_i(cmd), .req_i(in_data_i), .sts_o(sts), .offset_o(offset)
  );

  assign out_data_o.status       = status;
  assign out_data_o.block_offset = (status == StOk) ? offset : 12'd0;
endmodule

FILE: sv/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_props
// port level checks of the heap allocator
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"
module ffha_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ffha_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ffha_pkg::rsp_t out_data_o
);
  import ffha_pkg::*;

  `FFHA_ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `FFHA_ASSERT_IMPL(a_stat, clk_i, rst_ni, out_valid_o, out_data_o.status <= StNotAlloc)
  `FFHA_ASSERT_IMPL(a_off, clk_i, rst_ni, out_valid_o && out_data_o.status != StOk,
    out_data_o.block_offset == '0)
  `FFHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
endmodule

bind first_fit_heap_allocator ffha_props u_chk (.*);
